// ----- hdl/table_newton_interpolator_defines.svh -----
// Assertion macros shared by the interpolator checks.
`ifndef TABLE_NEWTON_INTERPOLATOR_DEFINES_SVH
`define TABLE_NEWTON_INTERPOLATOR_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define TNI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the following cycle.
`define TNI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tni_pkg.sv -----
// Types, constants and arithmetic helpers of the table interpolator.
package tni_pkg;

   localparam int MAX_NODES = 256;
   localparam int ADDR_W    = $clog2(MAX_NODES);
   localparam int NCNT_W    = $clog2(MAX_NODES + 1);
   localparam int MIN_NODES = 3;

   // Fixed field widths
   localparam int VAL_W  = 32;
   localparam int IDX_W  = 8;
   localparam int CNT_W  = 9;
   localparam int DEG_W  = 2;
   localparam int STAT_W = 2;
   localparam int CSR_W  = 9;

   // Wide Q.16 intermediates and the iterative unit
   localparam int WIDE_W    = 64;
   localparam int FRAC_W    = 16;
   localparam int MUL_STEPS = WIDE_W;
   localparam int DIV_STEPS = WIDE_W + FRAC_W;
   localparam int UCNT_W    = $clog2(DIV_STEPS);

   localparam logic signed [WIDE_W-1:0] SAT_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] OUT_MAX = WIDE_W'(64'sh7FFF_FFFF);
   localparam logic signed [WIDE_W-1:0] OUT_MIN = -OUT_MAX - WIDE_W'(1);

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_ERROR = 2'd2;

   // Command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_INTERP = 1'b1;

   // Register indexes
   localparam logic REG_DEGREE = 1'b0;
   localparam logic REG_COUNT  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_RD0, S_RDL, S_CHK, S_BRD, S_BUPD, S_BRK,
      S_LRD, S_LCAP, S_EQ, S_EXEC, S_SAT, S_FIN
   } state_type;

   typedef enum logic [2:0] {
      STEP_C1, STEP_E1, STEP_C2, STEP_T1, STEP_P, STEP_T2
   } step_type;

   // Add with symmetric saturation to +-(2^63-1)
   function automatic logic signed [WIDE_W-1:0] sat_add(
      input logic signed [WIDE_W-1:0] a,
      input logic signed [WIDE_W-1:0] b);
      logic signed [WIDE_W:0] s;
      s = (WIDE_W+1)'(a) + (WIDE_W+1)'(b);
      if (s > (WIDE_W+1)'(SAT_MAX))
         return SAT_MAX;
      else if (s < -(WIDE_W+1)'(SAT_MAX))
         return -SAT_MAX;
      else
         return s[WIDE_W-1:0];
   endfunction

   // Magnitude of a wide signed value
   function automatic logic [WIDE_W-1:0] mag(input logic signed [WIDE_W-1:0] a);
      return a[WIDE_W-1] ? WIDE_W'(-a) : WIDE_W'(a);
   endfunction

   // Sign-extend a table value to the wide format
   function automatic logic signed [WIDE_W-1:0] sx(input logic signed [VAL_W-1:0] a);
      return WIDE_W'(a);
   endfunction

endpackage

// ----- hdl/table_newton_interpolator.sv -----
// Table interpolator top level: node memory, bisection and Newton evaluation.
// Write item: the block passes through S_FIN, which registers the result once the output is free,
// and then returns to S_IDLE for the next item. Query: node memory reads (one per bisection step)
// plus the shared serial unit, which runs each division and each multiply of the Newton terms.
// One item is in work at a time; the result register frees it.
// Reset is synchronous: registers return to degree 1 and 3 nodes; table stays unwritten.
module table_newton_interpolator
   import tni_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [71:0]         req_tdata,  // node_index[7:0], x_value[39:8], f_value[71:40]
   input  logic [0:0]          req_tuser,  // command[0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,  // interp_value[31:0]
   output logic [STAT_W-1:0]   rsp_tuser,  // status[1:0]
   input  logic                csr_we,
   input  logic [0:0]          csr_addr,
   input  logic [CSR_W-1:0]    csr_wdata
);

   state_type state_ff, state_in;

   // Configuration
   logic [DEG_W-1:0] degree_ff;
   logic [CNT_W-1:0] node_count_ff;

   // Node memory {f, x}
   logic [2*VAL_W-1:0] mem [MAX_NODES];
   logic [2*VAL_W-1:0] mem_q_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic signed [VAL_W-1:0] mem_x, mem_f;

   // Query context
   logic signed [VAL_W-1:0] xc_ff, xki_ff, xkf_ff;
   logic [NCNT_W-1:0] n_ff;
   logic              d2_ff;
   logic [ADDR_W-1:0] ki_ff, kf_ff, km_ff, base_ff, km_c, ki_nx, kf_nx;
   logic [1:0]        ld_cnt_ff;
   logic signed [VAL_W-1:0] xs_ff [3];
   logic signed [VAL_W-1:0] fs_ff [3];

   // Coefficients and accumulator
   step_type step_ff;
   logic signed [WIDE_W-1:0] c1_ff, num2_ff, c2_ff, p_ff, acc_ff;

   // Serial multiply / divide unit
   logic                 u_busy_ff, u_done_ff, u_div_ff, u_neg_ff;
   logic [UCNT_W-1:0]    u_cnt_ff;
   logic [WIDE_W-1:0]    u_opnd_ff;
   logic [2*WIDE_W-1:0]  prod_ff;
   logic [DIV_STEPS-1:0] div_n_ff, div_q_ff;
   logic [WIDE_W-1:0]    div_r_ff;
   logic signed [WIDE_W-1:0] op_a, op_b, u_res;
   logic                 op_div, u_last, u_sat;
   logic [WIDE_W-2:0]    u_mag;
   logic [WIDE_W:0]      mul_sum, div_sh;
   logic                 div_ge;

   // Result register
   logic                rsp_valid_ff;
   logic [VAL_W-1:0]    rsp_data_ff;
   logic [STAT_W-1:0]   rsp_stat_ff;
   logic [VAL_W-1:0]    res_value_ff;
   logic [STAT_W-1:0]   res_stat_ff;

   // Decisions
   logic req_acc, out_free, range_out, same_side, bis_end, brk_bad, eq_bad;
   logic ld_last, step_last;
   logic [ADDR_W-1:0] last_idx;
   logic signed [VAL_W:0] dist_a, dist_b;
   logic [7:0] in_idx;
   logic signed [VAL_W-1:0] in_x, in_f;

   assign in_idx = req_tdata[7:0];
   assign in_x   = req_tdata[39:8];
   assign in_f   = req_tdata[71:40];

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

   assign mem_x = mem_q_ff[VAL_W-1:0];
   assign mem_f = mem_q_ff[2*VAL_W-1:VAL_W];
   assign last_idx = ADDR_W'(n_ff - NCNT_W'(1));

   // Comparisons against the query point
   assign range_out = (xki_ff > xc_ff && mem_x > xc_ff) || (xki_ff < xc_ff && mem_x < xc_ff);
   assign same_side = range_out;
   assign km_c  = ADDR_W'(({1'b0, ki_ff} + {1'b0, kf_ff}) >> 1);
   assign ki_nx = same_side ? km_ff : ki_ff;
   assign kf_nx = same_side ? kf_ff : km_ff;
   assign bis_end = (kf_nx - ki_nx) < ADDR_W'(2);
   assign brk_bad = (xki_ff > xc_ff) || (xkf_ff < xc_ff);
   assign dist_a = (VAL_W+1)'(xc_ff) - (VAL_W+1)'(xki_ff);
   assign dist_b = (VAL_W+1)'(xkf_ff) - (VAL_W+1)'(xc_ff);
   assign eq_bad = (xs_ff[1] == xs_ff[0]) ||
                   (d2_ff && (xs_ff[2] == xs_ff[1] || xs_ff[2] == xs_ff[0]));
   assign ld_last = (ld_cnt_ff == (d2_ff ? 2'd2 : 2'd1));
   assign step_last = (step_ff == STEP_T1 && !d2_ff) || (step_ff == STEP_T2);

   // Select the memory read address
   always_comb begin
      case (state_ff)
         S_RD0:   rd_addr = '0;
         S_RDL:   rd_addr = last_idx;
         S_BRD:   rd_addr = km_c;
         S_LRD:   rd_addr = base_ff + ADDR_W'(ld_cnt_ff);
         default: rd_addr = '0;
      endcase
   end

   // Write on accepted write items, read every cycle
   always_ff @(posedge clock) begin
      if (req_acc && req_tuser[0] == CMD_WRITE && 32'(in_idx) < MAX_NODES) begin
         mem[ADDR_W'(in_idx)] <= {in_f, in_x};
      end
      mem_q_ff <= mem[rd_addr];
   end

   // Pick operands of the current arithmetic step
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_div = 1'b1;
      case (step_ff)
         STEP_C1: begin
            op_a = sx(fs_ff[1]) - sx(fs_ff[0]);
            op_b = sx(xs_ff[1]) - sx(xs_ff[0]);
         end
         STEP_E1: begin
            op_a = sx(fs_ff[2]) - sx(fs_ff[1]);
            op_b = sx(xs_ff[2]) - sx(xs_ff[1]);
         end
         STEP_C2: begin
            op_a = num2_ff;
            op_b = sx(xs_ff[2]) - sx(xs_ff[0]);
         end
         STEP_T1: begin
            op_a   = c1_ff;
            op_b   = sx(xc_ff) - sx(xs_ff[0]);
            op_div = 1'b0;
         end
         STEP_P: begin
            op_a   = sx(xc_ff) - sx(xs_ff[0]);
            op_b   = sx(xc_ff) - sx(xs_ff[1]);
            op_div = 1'b0;
         end
         STEP_T2: begin
            op_a   = c2_ff;
            op_b   = p_ff;
            op_div = 1'b0;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // One unit step and the finished result
   assign mul_sum = {1'b0, prod_ff[2*WIDE_W-1:WIDE_W]} +
                    (prod_ff[0] ? {1'b0, u_opnd_ff} : '0);
   assign div_sh  = {div_r_ff, div_n_ff[DIV_STEPS-1]};
   assign div_ge  = div_sh >= {1'b0, u_opnd_ff};
   assign u_last  = u_div_ff ? (u_cnt_ff == UCNT_W'(DIV_STEPS - 1))
                             : (u_cnt_ff == UCNT_W'(MUL_STEPS - 1));
   assign u_sat   = u_div_ff ? (|div_q_ff[DIV_STEPS-1:WIDE_W-1])
                             : (|prod_ff[2*WIDE_W-1:WIDE_W+FRAC_W-1]);
   assign u_mag   = u_div_ff ? div_q_ff[WIDE_W-2:0]
                             : prod_ff[WIDE_W+FRAC_W-2:FRAC_W];
   always_comb begin
      if (u_sat)
         u_res = u_neg_ff ? -SAT_MAX : SAT_MAX;
      else if (u_neg_ff)
         u_res = -$signed({1'b0, u_mag});
      else
         u_res = $signed({1'b0, u_mag});
   end

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) state_in = (req_tuser[0] == CMD_INTERP) ? S_RD0 : S_FIN;
         end
         S_RD0:  state_in = S_RDL;
         S_RDL:  state_in = S_CHK;
         S_CHK:  state_in = range_out ? S_FIN : S_BRD;
         S_BRD:  state_in = S_BUPD;
         S_BUPD: state_in = bis_end ? S_BRK : S_BRD;
         S_BRK:  state_in = brk_bad ? S_FIN : S_LRD;
         S_LRD:  state_in = S_LCAP;
         S_LCAP: state_in = ld_last ? S_EQ : S_LRD;
         S_EQ:   state_in = eq_bad ? S_FIN : S_EXEC;
         S_EXEC: begin
            if (u_done_ff && step_last) state_in = S_SAT;
         end
         S_SAT:  state_in = S_FIN;
         S_FIN: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff     <= DEG_W'(1);
         node_count_ff <= CNT_W'(3);
         rsp_valid_ff  <= 1'b0;
         u_busy_ff     <= 1'b0;
         u_done_ff     <= 1'b0;
         u_cnt_ff      <= '0;
      end else begin
         if (csr_we && csr_addr[0] == REG_DEGREE) degree_ff <= csr_wdata[DEG_W-1:0];
         if (csr_we && csr_addr[0] == REG_COUNT)  node_count_ff <= csr_wdata[CNT_W-1:0];

         if (state_ff == S_FIN && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)               rsp_valid_ff <= 1'b0;

         u_done_ff <= 1'b0;
         if (state_ff == S_EXEC && !u_busy_ff && !u_done_ff) begin
            u_busy_ff <= 1'b1;
            u_cnt_ff  <= '0;
         end else if (u_busy_ff) begin
            u_cnt_ff <= u_cnt_ff + UCNT_W'(1);
            if (u_last) begin
               u_busy_ff <= 1'b0;
               u_done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            res_value_ff <= '0;
            res_stat_ff  <= ST_OK;
            xc_ff <= in_x;
            d2_ff <= degree_ff[1];
            if (32'(node_count_ff) < MIN_NODES)      n_ff <= NCNT_W'(MIN_NODES);
            else if (32'(node_count_ff) > MAX_NODES) n_ff <= NCNT_W'(MAX_NODES);
            else                                     n_ff <= NCNT_W'(node_count_ff);
         end
         S_RDL: begin
            xki_ff <= mem_x;
            ki_ff  <= '0;
            kf_ff  <= last_idx;
         end
         S_CHK: begin
            xkf_ff <= mem_x;
            if (range_out) res_stat_ff <= ST_RANGE;
         end
         S_BRD: km_ff <= km_c;
         S_BUPD: begin
            ki_ff <= ki_nx;
            kf_ff <= kf_nx;
            if (same_side) xki_ff <= mem_x;
            else           xkf_ff <= mem_x;
         end
         S_BRK: begin
            ld_cnt_ff <= 2'd0;
            if (brk_bad) res_stat_ff <= ST_ERROR;
            if (!d2_ff)                                          base_ff <= ki_ff;
            else if (ki_ff == '0)                                base_ff <= '0;
            else if (NCNT_W'(ki_ff) == n_ff - NCNT_W'(2))        base_ff <= ki_ff - ADDR_W'(1);
            else if (dist_a < dist_b)                            base_ff <= ki_ff - ADDR_W'(1);
            else                                                 base_ff <= ki_ff;
         end
         S_LCAP: begin
            xs_ff[ld_cnt_ff] <= mem_x;
            fs_ff[ld_cnt_ff] <= mem_f;
            ld_cnt_ff <= ld_cnt_ff + 2'd1;
         end
         S_EQ: begin
            step_ff <= STEP_C1;
            if (eq_bad) res_stat_ff <= ST_ERROR;
         end
         S_EXEC: begin
            // Start the unit on the step's operands
            if (!u_busy_ff && !u_done_ff) begin
               u_div_ff <= op_div;
               u_neg_ff <= op_a[WIDE_W-1] ^ op_b[WIDE_W-1];
               if (op_div) begin
                  u_opnd_ff <= mag(op_b);
                  div_n_ff  <= {mag(op_a), {FRAC_W{1'b0}}};
                  div_r_ff  <= '0;
                  div_q_ff  <= '0;
               end else begin
                  u_opnd_ff <= mag(op_a);
                  prod_ff   <= {{WIDE_W{1'b0}}, mag(op_b)};
               end
            end
            // Iterate: shift-add multiply or restoring divide
            if (u_busy_ff) begin
               if (u_div_ff) begin
                  div_n_ff <= {div_n_ff[DIV_STEPS-2:0], 1'b0};
                  div_q_ff <= {div_q_ff[DIV_STEPS-2:0], div_ge};
                  div_r_ff <= div_ge ? WIDE_W'(div_sh - {1'b0, u_opnd_ff})
                                     : WIDE_W'(div_sh);
               end else begin
                  prod_ff <= {mul_sum, prod_ff[WIDE_W-1:1]};
               end
            end
            // Store the result and move to the next step
            if (u_done_ff) begin
               case (step_ff)
                  STEP_C1: begin
                     c1_ff   <= u_res;
                     step_ff <= d2_ff ? STEP_E1 : STEP_T1;
                  end
                  STEP_E1: begin
                     num2_ff <= sat_add(u_res, -c1_ff);
                     step_ff <= STEP_C2;
                  end
                  STEP_C2: begin
                     c2_ff   <= u_res;
                     step_ff <= STEP_T1;
                  end
                  STEP_T1: begin
                     acc_ff  <= sat_add(sx(fs_ff[0]), u_res);
                     step_ff <= STEP_P;
                  end
                  STEP_P: begin
                     p_ff    <= u_res;
                     step_ff <= STEP_T2;
                  end
                  STEP_T2: acc_ff <= sat_add(acc_ff, u_res);
                  default: step_ff <= STEP_C1;
               endcase
            end
         end
         S_SAT: begin
            if (acc_ff > OUT_MAX)      res_value_ff <= VAL_W'(OUT_MAX);
            else if (acc_ff < OUT_MIN) res_value_ff <= VAL_W'(OUT_MIN);
            else                       res_value_ff <= acc_ff[VAL_W-1:0];
         end
         S_FIN: begin
            if (out_free) begin
               rsp_data_ff <= res_value_ff;
               rsp_stat_ff <= res_stat_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hdl/tni_checker.sv -----
// Port-level checks of the table interpolator and their binding.
`include "table_newton_interpolator_defines.svh"

module tni_checker
   import tni_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [31:0]       rsp_tdata,
   input logic [STAT_W-1:0] rsp_tuser
);

   // A stalled item keeps its value
   `TNI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result item changed while stalled")
   // Only defined status codes leave the block
   `TNI_ASSERT_NOW(a_stat_code, clock, reset, rsp_tvalid, rsp_tuser == ST_OK || rsp_tuser == ST_RANGE || rsp_tuser == ST_ERROR, "undefined status code")
   // A failed query carries a zero value
   `TNI_ASSERT_NOW(a_fail_zero, clock, reset, rsp_tvalid && rsp_tuser != ST_OK, rsp_tdata == '0, "nonzero value with failing status")
   // One item at a time: an accept closes the input for the next cycle
   `TNI_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "input open right after an accept")

endmodule

bind table_newton_interpolator tni_checker u_tni_checker (.*);
